FILE: hw/rtl/text_or_length_frame_deframer_unit_defines.svh
// ---------------------------------------------------------------------------
// Text or length frame deframer - assertion macros
// Shared assertion helpers, clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef TEXT_OR_LENGTH_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define TEXT_OR_LENGTH_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication
`define TLFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tlfd_pkg.sv
// ---------------------------------------------------------------------------
// Text or length frame deframer - package
// Field widths, opcodes, framing characters and inter-module structs.
// ---------------------------------------------------------------------------
package tlfd_pkg;

  // field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned ELAP_W  = 17;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned MAX_OUT = 32;
  localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);

  // opcodes
  localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_START = 2'd2;

  // framing characters
  localparam logic [BYTE_W-1:0] START_BIN  = 8'hF1;
  localparam logic [BYTE_W-1:0] START_PLUS = 8'h2B;
  localparam logic [BYTE_W-1:0] START_OK   = 8'h4F;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;

  localparam logic [ELAP_W-1:0] ELAPSED_MAX = 17'h1FFFF;

  // readout request from parser to reader
  typedef struct packed {
    logic             valid;
    logic             timeout;
    logic             kind;
    logic [CNT_W-1:0] count;
  } emit_req_t;

  // reader status back to parser
  typedef struct packed {
    logic busy;
  } reader_stat_t;

endpackage

FILE: hw/rtl/tlfd_in_if.sv
// ---------------------------------------------------------------------------
// Text or length frame deframer - input channel
// Valid/ready channel carrying one received byte, tick or start item.
// ---------------------------------------------------------------------------
interface tlfd_in_if;
  import tlfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [BYTE_W-1:0] rx_byte;
  logic [TICK_W-1:0] timeout_ticks;

  modport source (output valid, output opcode, output rx_byte, output timeout_ticks,
                  input ready);
  modport sink   (input valid, input opcode, input rx_byte, input timeout_ticks,
                  output ready);
endinterface

FILE: hw/rtl/tlfd_out_if.sv
// ---------------------------------------------------------------------------
// Text or length frame deframer - output channel
// Valid/ready channel carrying one frame byte or timeout result.
// ---------------------------------------------------------------------------
interface tlfd_out_if;
  import tlfd_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic              frame_kind;
  logic [BYTE_W-1:0] frame_byte;
  logic [POS_W-1:0]  byte_position;
  logic              last;

  modport source (output valid, output status, output frame_kind, output frame_byte,
                  output byte_position, output last, input ready);
  modport sink   (input valid, input status, input frame_kind, input frame_byte,
                  input byte_position, input last, output ready);
endinterface

FILE: hw/rtl/tlfd_ram.sv
// ---------------------------------------------------------------------------
// Text or length frame deframer - generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tlfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/tlfd_parser.sv
// ---------------------------------------------------------------------------
// Text or length frame deframer - parser
// Hunts for a start byte, writes frame bytes into the store and decides
// when a frame is complete or the tick budget has run out.
// ---------------------------------------------------------------------------
module tlfd_parser #(
  parameter int unsigned BufferBytes = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [tlfd_pkg::OP_W-1:0]        opcode_i,
  input  logic [tlfd_pkg::BYTE_W-1:0]      rx_byte_i,
  input  logic [tlfd_pkg::TICK_W-1:0]      timeout_ticks_i,
  input  tlfd_pkg::reader_stat_t           stat_i,
  output logic                             we_o,
  output logic [$clog2(BufferBytes)-1:0]   waddr_o,
  output logic [tlfd_pkg::BYTE_W-1:0]      wdata_o,
  output tlfd_pkg::emit_req_t              req_o
);
  import tlfd_pkg::*;

  localparam int unsigned FillW = $clog2(BufferBytes + 1);
  localparam int unsigned AddrW = $clog2(BufferBytes);
  localparam int unsigned CmpW  = (FillW > CNT_W) ? FillW : CNT_W;

  logic [FillW-1:0]  fill_q, fill_d;
  logic [BYTE_W-1:0] rem_q, rem_d;
  logic [ELAP_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [TICK_W-1:0] limit_q, limit_d;
  logic              armed_q, armed_d;
  logic              kind_q, kind_d;

  logic              accept;
  logic              store;
  logic              done;
  logic              emit;
  logic              is_start;
  logic [FillW-1:0]  emit_n;
  logic [CmpW-1:0]   emit_ext;

  assign in_ready_o  = !stat_i.busy;
  assign accept      = in_valid_i && in_ready_o;
  assign is_start    = (rx_byte_i == START_PLUS) || (rx_byte_i == START_OK) ||
                       (rx_byte_i == START_BIN);
  assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + ELAP_W'(1);

  // next state of the read
  always_comb begin
    fill_d    = fill_q;
    rem_d     = rem_q;
    elapsed_d = elapsed_q;
    limit_d   = limit_q;
    armed_d   = armed_q;
    kind_d    = kind_q;
    store     = 1'b0;
    done      = 1'b0;
    emit      = 1'b0;
    emit_n    = fill_q;
    req_o     = '0;
    if (accept) begin
      unique case (opcode_i)
        OP_START: begin
          fill_d    = '0;
          rem_d     = '0;
          elapsed_d = '0;
          limit_d   = timeout_ticks_i;
          armed_d   = 1'b1;
        end
        OP_TICK: begin
          if (armed_q) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc > {1'b0, limit_q}) begin
              req_o.valid   = 1'b1;
              req_o.timeout = 1'b1;
              armed_d       = 1'b0;
              fill_d        = '0;
            end
          end
        end
        OP_BYTE: begin
          if (armed_q) begin
            if (fill_q >= FillW'(BufferBytes)) begin
              // store full: empty it and drop the byte
              fill_d = '0;
            end else if (fill_q != '0 || is_start) begin
              store = 1'b1;
              if (fill_q == FillW'(2) && kind_q) begin
                rem_d = rx_byte_i;
              end else if (rem_q != '0) begin
                rem_d = rem_q - BYTE_W'(1);
                done  = (rem_q == BYTE_W'(1));
              end else if (fill_q != '0 && !kind_q) begin
                if (rx_byte_i == CHAR_CR) begin
                  store = 1'b0;
                end else if (rx_byte_i == CHAR_LF) begin
                  store = 1'b0;
                  emit  = 1'b1;
                end
              end
              if (store) begin
                if (fill_q == '0) begin
                  kind_d = (rx_byte_i == START_BIN);
                end
                fill_d = fill_q + FillW'(1);
                emit_n = fill_q + FillW'(1);
                emit   = done;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    // completed frame: hand over to the reader, capped at the output limit
    emit_ext = CmpW'(emit_n);
    if (emit) begin
      req_o.valid = 1'b1;
      req_o.kind  = kind_d;
      req_o.count = (emit_ext > CmpW'(MAX_OUT)) ? CNT_W'(MAX_OUT) : CNT_W'(emit_ext);
      armed_d     = 1'b0;
      fill_d      = '0;
    end
  end

  assign we_o    = store;
  assign waddr_o = fill_q[AddrW-1:0];
  assign wdata_o = rx_byte_i;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      rem_q     <= '0;
      elapsed_q <= '0;
      limit_q   <= '0;
      armed_q   <= 1'b0;
      kind_q    <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      rem_q     <= rem_d;
      elapsed_q <= elapsed_d;
      limit_q   <= limit_d;
      armed_q   <= armed_d;
      kind_q    <= kind_d;
    end
  end

endmodule

FILE: hw/rtl/tlfd_reader.sv
// ---------------------------------------------------------------------------
// Text or length frame deframer - reader
// Walks the store one byte per read and drives the result register,
// or gives the single timeout result.
// ---------------------------------------------------------------------------
module tlfd_reader #(
  parameter int unsigned BufferBytes = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tlfd_pkg::emit_req_t              req_i,
  output tlfd_pkg::reader_stat_t           stat_o,
  output logic                             re_o,
  output logic [$clog2(BufferBytes)-1:0]   raddr_o,
  input  logic [tlfd_pkg::BYTE_W-1:0]      rdata_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             status_o,
  output logic                             frame_kind_o,
  output logic [tlfd_pkg::BYTE_W-1:0]      frame_byte_o,
  output logic [tlfd_pkg::POS_W-1:0]       byte_position_o,
  output logic                             last_o
);
  import tlfd_pkg::*;

  localparam int unsigned AddrW = $clog2(BufferBytes);

  typedef enum logic [1:0] {
    R_IDLE,
    R_READ,
    R_DRAIN
  } rd_state_e;

  rd_state_e        state_q;
  logic [CNT_W-1:0] ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             kind_q;
  logic             valid_q;
  logic             status_q;
  logic [POS_W-1:0] pos_q;
  logic             last_q;

  logic             issue;
  logic             taken;
  logic             is_final;

  assign taken    = valid_q && out_ready_i;
  assign issue    = (state_q == R_READ) && (!valid_q || out_ready_i);
  assign is_final = ((ptr_q + CNT_W'(1)) == cnt_q);

  assign re_o    = issue;
  assign raddr_o = AddrW'(ptr_q);

  // readout sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= R_IDLE;
      valid_q  <= 1'b0;
      status_q <= 1'b0;
      ptr_q    <= '0;
      cnt_q    <= '0;
      kind_q   <= 1'b0;
      pos_q    <= '0;
      last_q   <= 1'b0;
    end else begin
      unique case (state_q)
        R_IDLE: begin
          if (req_i.valid && req_i.timeout) begin
            valid_q  <= 1'b1;
            status_q <= 1'b1;
            pos_q    <= '0;
            last_q   <= 1'b1;
            state_q  <= R_DRAIN;
          end else if (req_i.valid) begin
            ptr_q    <= '0;
            cnt_q    <= req_i.count;
            kind_q   <= req_i.kind;
            status_q <= 1'b0;
            state_q  <= R_READ;
          end
        end
        R_READ: begin
          if (issue) begin
            valid_q <= 1'b1;
            pos_q   <= ptr_q[POS_W-1:0];
            last_q  <= is_final;
            ptr_q   <= ptr_q + CNT_W'(1);
            if (is_final) begin
              state_q <= R_DRAIN;
            end
          end else if (taken) begin
            valid_q <= 1'b0;
          end
        end
        R_DRAIN: begin
          if (taken) begin
            valid_q <= 1'b0;
            state_q <= R_IDLE;
          end
        end
        default: begin
          state_q <= R_IDLE;
        end
      endcase
    end
  end

  assign stat_o.busy     = (state_q != R_IDLE);
  assign out_valid_o     = valid_q;
  assign status_o        = status_q;
  assign frame_kind_o    = status_q ? 1'b0 : kind_q;
  assign frame_byte_o    = status_q ? '0 : rdata_i;
  assign byte_position_o = pos_q;
  assign last_o          = last_q;

endmodule

FILE: hw/rtl/text_or_length_frame_deframer_unit.sv
// ---------------------------------------------------------------------------
// Text or length frame deframer unit
// Captures one text line or length-counted binary frame per armed read.
// ---------------------------------------------------------------------------
// A start item arms a read with a tick budget; received bytes are then
// parsed and written into a frame store RAM, one item per cycle while the
// reader is idle. When a frame completes, the input stops accepting items
// and the frame is read back out of the store through its single read port,
// one byte per cycle while the result side keeps ready high. A timeout gives
// one result and holds the input until that result is taken.
// The store needs no clearing after reset.
module text_or_length_frame_deframer_unit #(
  parameter int unsigned BufferBytes = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tlfd_in_if.sink     in_i,
  tlfd_out_if.source  out_o
);
  import tlfd_pkg::*;

  localparam int unsigned AddrW = $clog2(BufferBytes);

  emit_req_t         req;
  reader_stat_t      stat;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [BYTE_W-1:0] wdata;
  logic              re;
  logic [AddrW-1:0]  raddr;
  logic [BYTE_W-1:0] rdata;

  // parser and store writes
  tlfd_parser #(.BufferBytes(BufferBytes)) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .opcode_i        (in_i.opcode),
    .rx_byte_i       (in_i.rx_byte),
    .timeout_ticks_i (in_i.timeout_ticks),
    .stat_i          (stat),
    .we_o            (we),
    .waddr_o         (waddr),
    .wdata_o         (wdata),
    .req_o           (req)
  );

  // frame store
  tlfd_ram #(.Width(BYTE_W), .Depth(BufferBytes)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // readout
  tlfd_reader #(.BufferBytes(BufferBytes)) u_reader (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req),
    .stat_o          (stat),
    .re_o            (re),
    .raddr_o         (raddr),
    .rdata_i         (rdata),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .status_o        (out_o.status),
    .frame_kind_o    (out_o.frame_kind),
    .frame_byte_o    (out_o.frame_byte),
    .byte_position_o (out_o.byte_position),
    .last_o          (out_o.last)
  );

endmodule

FILE: hw/rtl/tlfd_checker.sv
// ---------------------------------------------------------------------------
// Text or length frame deframer - port checker
// Checks result sequencing and input holdoff seen at the top-level ports.
// ---------------------------------------------------------------------------
`include "text_or_length_frame_deframer_unit_defines.svh"

module tlfd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [tlfd_pkg::OP_W-1:0]     opcode_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          status_i,
  input logic                          frame_kind_i,
  input logic [tlfd_pkg::BYTE_W-1:0]   frame_byte_i,
  input logic [tlfd_pkg::POS_W-1:0]    byte_position_i,
  input logic                          last_i
);
  import tlfd_pkg::*;

  // a timeout result is a lone last result with empty fields
  `TLFD_ASSERT_NOW(a_timeout_shape, out_valid_i && status_i, last_i && !frame_kind_i && frame_byte_i == '0 && byte_position_i == '0, "timeout result malformed")

  // no item is taken while a result waits
  `TLFD_ASSERT_NOW(a_hold_input, out_valid_i, !in_ready_i, "input ready while result pending")

  // frame bytes come out in consecutive positions
  `TLFD_ASSERT_NEXT(a_pos_step, out_valid_i && out_ready_i && !last_i, !out_valid_i || byte_position_i == $past(byte_position_i) + POS_W'(1), "frame position skipped")

  // a start item gives no result
  `TLFD_ASSERT_NEXT(a_start_silent, in_valid_i && in_ready_i && opcode_i == OP_START, !out_valid_i, "result after start item")

endmodule

bind text_or_length_frame_deframer_unit tlfd_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .opcode_i        (in_i.opcode),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .status_i        (out_o.status),
  .frame_kind_i    (out_o.frame_kind),
  .frame_byte_i    (out_o.frame_byte),
  .byte_position_i (out_o.byte_position),
  .last_i          (out_o.last)
);
